// File: design/fup_pkg.sv
// Shared types and codes for the form-urlencoded field parser.
package fup_pkg;

  // Result kinds
  localparam logic [1:0] KIND_VALUE     = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_DONE      = 2'd2;

  // Escape progress
  localparam logic [1:0] PCT_NONE  = 2'd0;
  localparam logic [1:0] PCT_FIRST = 2'd1;
  localparam logic [1:0] PCT_BOTH  = 2'd2;

  // Register indexes
  localparam logic [2:0] CFG_VALUE_LIMIT = 3'd6;
  localparam logic [7:0] VALUE_LIMIT_RESET = 8'd63;

  // Significant characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } fup_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] field_index;
    logic [7:0] value_byte;
    logic [7:0] value_length;
    logic [5:0] parsed_mask;
    logic       last;
  } fup_out_t;

  // Hex nibble of an escape character
  function automatic logic [3:0] nib(input logic [7:0] c);
    logic [3:0] add;
    add = c[6] ? 4'd9 : 4'd0;
    return c[3:0] + add;
  endfunction

endpackage

// File: design/form_urlencoded_field_parser_unit.sv
// Form-urlencoded field parser: key match, value decode, result queue.
// Throughput: one byte per cycle while each byte gives at most one result and out_stall
// is low; results leave one per cycle unless out_stall is high, from an 8-entry queue,
// and input stalls while more than 4 wait; results are shown from registered entries.
// A byte can cause up to 4 results (escape flush, field end and done on the final byte).
// Reset (rst, synchronous) clears the parse state, the key registers and the queue.
module form_urlencoded_field_parser_unit #(
  parameter int NUM_KEYS  = 6,
  parameter int KEY_CHARS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  fup_pkg::fup_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fup_pkg::fup_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);
  import fup_pkg::*;

  localparam int KW  = 8 * KEY_CHARS;
  localparam int KLW = $clog2(KEY_CHARS + 1);
  localparam int QD  = 8;
  localparam int QAW = $clog2(QD);
  localparam int MAX_PUSH = 4;

  // Configuration registers
  logic [KW-1:0]       key_q [NUM_KEYS];
  logic [7:0]          value_limit;

  // Parse state
  logic                in_value;
  logic [1:0]          segment_position;
  logic [KW-1:0]       key_collect;
  logic                key_too_long;
  logic [KLW-1:0]      key_length;
  logic [2:0]          active_field;
  logic                active_valid;
  logic [7:0]          emitted_count;
  logic [1:0]          percent_phase;
  logic [7:0]          percent_first;
  logic [NUM_KEYS-1:0] seen_mask;

  logic                in_value_next;
  logic [1:0]          segment_position_next;
  logic [KW-1:0]       key_collect_next;
  logic                key_too_long_next;
  logic [KLW-1:0]      key_length_next;
  logic [2:0]          active_field_next;
  logic                active_valid_next;
  logic [7:0]          emitted_count_next;
  logic [1:0]          percent_phase_next;
  logic [7:0]          percent_first_next;
  logic [NUM_KEYS-1:0] seen_mask_next;

  // Result queue
  fup_out_t            queue [QD];
  logic [QAW-1:0]      wr_ptr;
  logic [QAW-1:0]      rd_ptr;
  logic [QAW:0]        count;

  fup_out_t            res [MAX_PUSH];
  logic [2:0]          n_push;
  logic                in_acc;
  logic                out_acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (count > (QAW+1)'(QD - MAX_PUSH));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = queue[rd_ptr];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) key_q[i] <= '0;
      value_limit <= VALUE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        if (cfg_index == 3'(i)) key_q[i] <= cfg_data[KW-1:0];
      end
      if (cfg_index == CFG_VALUE_LIMIT) value_limit <= cfg_data[7:0];
    end
  end

  // Step the parser on one byte and gather its results
  always_comb begin
    logic [7:0] b;
    logic       ended;
    logic       seg_end;
    logic       do_end_key;
    logic       hit;
    logic [2:0] hit_idx;
    logic [7:0] vb;
    logic       vb_en;

    b     = in_data.data_byte;
    ended = 1'b0;
    do_end_key = 1'b0;
    vb    = '0;
    vb_en = 1'b0;
    n_push = '0;
    for (int s = 0; s < MAX_PUSH; s++) res[s] = '0;

    in_value_next         = in_value;
    segment_position_next = segment_position;
    key_collect_next      = key_collect;
    key_too_long_next     = key_too_long;
    key_length_next       = key_length;
    active_field_next     = active_field;
    active_valid_next     = active_valid;
    emitted_count_next    = emitted_count;
    percent_phase_next    = percent_phase;
    percent_first_next    = percent_first;
    seen_mask_next        = seen_mask;

    // Byte within a segment: collect key or decode value
    if (b == CH_AMP && segment_position == 2'd2) begin
      ended = 1'b1;
    end else begin
      if (!in_value) begin
        if (b == CH_EQUAL && segment_position != 2'd0) begin
          do_end_key = 1'b1;
        end else if (key_length < KLW'(KEY_CHARS)) begin
          for (int j = 0; j < KEY_CHARS; j++) begin
            if (key_length == KLW'(j)) key_collect_next[8*j +: 8] = b;
          end
          key_length_next = key_length + KLW'(1);
        end else begin
          key_too_long_next = 1'b1;
        end
      end else begin
        case (percent_phase)
          PCT_NONE: begin
            if (b == CH_PERCENT) begin
              percent_phase_next = PCT_FIRST;
            end else begin
              vb_en = 1'b1;
              vb    = (b == CH_PLUS) ? CH_SPACE : b;
            end
          end
          PCT_FIRST: begin
            percent_first_next = b;
            percent_phase_next = PCT_BOTH;
          end
          default: begin
            vb_en = 1'b1;
            vb    = {nib(percent_first), nib(b)};
            percent_phase_next = PCT_NONE;
          end
        endcase
      end
      segment_position_next = (segment_position == 2'd2) ? 2'd2 :
                              segment_position + 2'd1;
    end

    // Emit the decoded byte within the limit
    if (vb_en && active_valid_next && emitted_count_next < value_limit) begin
      res[n_push[1:0]].kind        = KIND_VALUE;
      res[n_push[1:0]].field_index = active_field_next;
      res[n_push[1:0]].value_byte  = vb;
      n_push             = n_push + 3'd1;
      emitted_count_next = emitted_count_next + 8'd1;
    end

    seg_end = ended || in_data.final_byte;
    if (seg_end && !in_value_next) do_end_key = 1'b1;

    // Match the key; lowest index wins
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (key_q[i] != '0 && key_q[i] == key_collect_next) begin
        hit     = 1'b1;
        hit_idx = 3'(i);
      end
    end

    // Close the key and open a new field on a fresh match
    if (do_end_key) begin
      active_valid_next = 1'b0;
      in_value_next     = 1'b1;
      if (!key_too_long_next && key_length_next != '0 && hit &&
          !seen_mask[hit_idx]) begin
        seen_mask_next[hit_idx] = 1'b1;
        active_valid_next  = 1'b1;
        active_field_next  = hit_idx;
        emitted_count_next = '0;
      end
    end

    // End the segment: flush a cut escape, report the field end
    if (seg_end) begin
      if (percent_phase_next != PCT_NONE && active_valid_next &&
          emitted_count_next < value_limit) begin
        res[n_push[1:0]].kind        = KIND_VALUE;
        res[n_push[1:0]].field_index = active_field_next;
        res[n_push[1:0]].value_byte  = CH_PERCENT;
        n_push             = n_push + 3'd1;
        emitted_count_next = emitted_count_next + 8'd1;
      end
      if (percent_phase_next == PCT_BOTH && active_valid_next &&
          emitted_count_next < value_limit) begin
        res[n_push[1:0]].kind        = KIND_VALUE;
        res[n_push[1:0]].field_index = active_field_next;
        res[n_push[1:0]].value_byte  = (percent_first_next == CH_PLUS) ? CH_SPACE :
                                       percent_first_next;
        n_push             = n_push + 3'd1;
        emitted_count_next = emitted_count_next + 8'd1;
      end
      if (active_valid_next) begin
        res[n_push[1:0]].kind         = KIND_FIELD_END;
        res[n_push[1:0]].field_index  = active_field_next;
        res[n_push[1:0]].value_length = emitted_count_next;
        n_push = n_push + 3'd1;
      end
      in_value_next         = 1'b0;
      segment_position_next = '0;
      key_collect_next      = '0;
      key_too_long_next     = 1'b0;
      key_length_next       = '0;
      active_valid_next     = 1'b0;
      emitted_count_next    = '0;
      percent_phase_next    = PCT_NONE;
      percent_first_next    = '0;
    end

    // Close the request with the parsed mask
    if (in_data.final_byte) begin
      res[n_push[1:0]].kind        = KIND_DONE;
      res[n_push[1:0]].parsed_mask = 6'(seen_mask_next);
      n_push         = n_push + 3'd1;
      seen_mask_next = '0;
    end

    // Mark the last result of this byte
    for (int s = 0; s < MAX_PUSH; s++) begin
      if (n_push == 3'(s + 1)) res[s].last = 1'b1;
    end
  end

  // Advance parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_value         <= 1'b0;
      segment_position <= '0;
      key_collect      <= '0;
      key_too_long     <= 1'b0;
      key_length       <= '0;
      active_field     <= '0;
      active_valid     <= 1'b0;
      emitted_count    <= '0;
      percent_phase    <= PCT_NONE;
      percent_first    <= '0;
      seen_mask        <= '0;
    end else if (in_acc) begin
      in_value         <= in_value_next;
      segment_position <= segment_position_next;
      key_collect      <= key_collect_next;
      key_too_long     <= key_too_long_next;
      key_length       <= key_length_next;
      active_field     <= active_field_next;
      active_valid     <= active_valid_next;
      emitted_count    <= emitted_count_next;
      percent_phase    <= percent_phase_next;
      percent_first    <= percent_first_next;
      seen_mask        <= seen_mask_next;
    end
  end

  // Load the results of a byte into consecutive queue entries
  always_ff @(posedge clk) begin
    for (int e = 0; e < QD; e++) begin
      logic [QAW-1:0] off;
      off = QAW'(e) - wr_ptr;
      if (in_acc && 3'(off) < n_push) queue[e] <= res[off[1:0]];
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) wr_ptr <= wr_ptr + QAW'(n_push);
      if (out_acc) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (in_acc ? (QAW+1)'(n_push) : '0) - (QAW+1)'(out_acc);
    end
  end

endmodule

// File: design/fup_checker.sv
// Port-level checks for the form-urlencoded field parser, bound to the parser unit.
module fup_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input fup_pkg::fup_out_t out_data
);
  import fup_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Done always closes the results of a byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_DONE |-> out_data.last)
    else $error("done result without last");

  // Field results carry no mask
  a_mask_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_DONE |-> out_data.parsed_mask == '0)
    else $error("mask set on a field result");

  // Drop all results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind form_urlencoded_field_parser_unit fup_checker u_fup_checker (.*);

// File: sim/fup_checker.sv
// Checker for the form-urlencoded field parser: predicts results and compares them.
module fup_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  fup_pkg::fup_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  fup_pkg::fup_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import fup_pkg::*;

  localparam int NUM_KEY_SLOTS = 6;
  localparam int KEY_BYTES     = 8;

  // Shadow registers
  logic [63:0] key_table [NUM_KEY_SLOTS];
  logic [7:0]  byte_limit;

  // Shadow parse state
  logic        in_value;
  logic [1:0]  seg_pos;
  logic [63:0] key_text;
  logic        key_overflow;
  logic [3:0]  key_len;
  logic [2:0]  cur_field;
  logic        cur_open;
  logic [7:0]  emit_count;
  logic [1:0]  pct_state;
  logic [7:0]  pct_held;
  logic [5:0]  seen_keys;

  fup_out_t step_out[$];
  fup_out_t decoded_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] sum;
    sum = c + (c[6] ? 8'd9 : 8'd0);
    return sum[3:0];
  endfunction

  function automatic void push_result(input logic [1:0] kind, input logic [2:0] idx,
                                      input logic [7:0] vb, input logic [7:0] len,
                                      input logic [5:0] mask);
    fup_out_t r;
    r.kind         = kind;
    r.field_index  = idx;
    r.value_byte   = vb;
    r.value_length = len;
    r.parsed_mask  = mask;
    r.last         = 1'b0;
    step_out.push_back(r);
  endfunction

  // Emit one decoded byte while the field is open and under the limit
  function automatic void emit_value(input logic [7:0] b);
    if (cur_open && emit_count < byte_limit) begin
      push_result(KIND_VALUE, cur_field, b, 8'd0, 6'd0);
      emit_count++;
    end
  endfunction

  // Finish the key: lowest matching slot wins, a repeated key stays closed
  function automatic void close_key();
    cur_open = 1'b0;
    in_value = 1'b1;
    if (key_overflow || key_len == 0) return;
    for (int i = 0; i < NUM_KEY_SLOTS; i++) begin
      if (key_table[i] != 64'd0 && key_table[i] == key_text) begin
        if (seen_keys[i]) return;
        seen_keys[i] = 1'b1;
        cur_open     = 1'b1;
        cur_field    = 3'(i);
        emit_count   = 8'd0;
        return;
      end
    end
  endfunction

  function automatic void clear_segment();
    in_value     = 1'b0;
    seg_pos      = 2'd0;
    key_text     = 64'd0;
    key_overflow = 1'b0;
    key_len      = 4'd0;
    cur_open     = 1'b0;
    emit_count   = 8'd0;
    pct_state    = PCT_NONE;
    pct_held     = 8'd0;
  endfunction

  // Close the segment: flush a cut-short escape, then report the field
  function automatic void end_segment();
    if (!in_value) close_key();
    if (pct_state != PCT_NONE) emit_value(CH_PERCENT);
    if (pct_state == PCT_BOTH) emit_value(pct_held == CH_PLUS ? CH_SPACE : pct_held);
    if (cur_open) push_result(KIND_FIELD_END, cur_field, 8'd0, emit_count, 6'd0);
    clear_segment();
  endfunction

  // Work out every result one accepted word causes
  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic     ended;
    logic [1:0] pos;
    fup_out_t r;
    ended = 1'b0;
    pos   = seg_pos;
    step_out.delete();
    if (b == CH_AMP && pos >= 2) begin
      end_segment();
      ended = 1'b1;
    end else begin
      if (!in_value) begin
        if (b == CH_EQUAL && pos >= 1) begin
          close_key();
        end else if (key_len < KEY_BYTES) begin
          key_text[8*key_len +: 8] = b;
          key_len++;
        end else begin
          key_overflow = 1'b1;
        end
      end else if (pct_state == PCT_NONE) begin
        if (b == CH_PERCENT) pct_state = PCT_FIRST;
        else emit_value(b == CH_PLUS ? CH_SPACE : b);
      end else if (pct_state == PCT_FIRST) begin
        pct_held  = b;
        pct_state = PCT_BOTH;
      end else begin
        emit_value({hex_nibble(pct_held), hex_nibble(b)});
        pct_state = PCT_NONE;
      end
      seg_pos = (pos < 2) ? pos + 2'd1 : 2'd2;
    end
    if (fin) begin
      if (!ended) end_segment();
      push_result(KIND_DONE, 3'd0, 8'd0, 8'd0, seen_keys);
      seen_keys = 6'd0;
    end
    // Mark the final result of the word and queue them all
    while (step_out.size() > 0) begin
      r      = step_out.pop_front();
      r.last = (step_out.size() == 0);
      decoded_results.push_back(r);
    end
  endfunction

  // Compare one accepted result word against the oldest prediction
  function automatic void check_result(input fup_out_t got);
    fup_out_t exp_r;
    if (decoded_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind %0d idx %0d byte %02h len %0d mask %02h last %0d",
                 got.kind, got.field_index, got.value_byte, got.value_length,
                 got.parsed_mask, got.last);
      return;
    end
    exp_r = decoded_results.pop_front();
    if (got.kind !== exp_r.kind || got.field_index !== exp_r.field_index ||
        got.value_byte !== exp_r.value_byte || got.value_length !== exp_r.value_length ||
        got.parsed_mask !== exp_r.parsed_mask || got.last !== exp_r.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected kind %0d idx %0d byte %02h len %0d mask %02h last %0d",
                 exp_r.kind, exp_r.field_index, exp_r.value_byte, exp_r.value_length,
                 exp_r.parsed_mask, exp_r.last);
        $display("          actual   kind %0d idx %0d byte %02h len %0d mask %02h last %0d",
                 got.kind, got.field_index, got.value_byte, got.value_length,
                 got.parsed_mask, got.last);
      end
    end
  endfunction

  // Track register writes, predict on accepted input, check accepted output
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEY_SLOTS; i++) key_table[i] = 64'd0;
      byte_limit = VALUE_LIMIT_RESET;
      clear_segment();
      cur_field = 3'd0;
      seen_keys = 6'd0;
      decoded_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < NUM_KEY_SLOTS) key_table[cfg_index] = cfg_data;
        else if (cfg_index == CFG_VALUE_LIMIT) byte_limit = cfg_data[7:0];
      end
      if (in_valid && !in_stall) parse_byte(in_data.data_byte, in_data.final_byte);
      if (out_valid && !out_stall) check_result(out_data);
    end
    pending = decoded_results.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the form-urlencoded field parser: stimulus, stalls and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fup_pkg::*;

  localparam int NUM_KEY_SLOTS = 6;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  fup_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  fup_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data  = 64'd0;
  int          errors;
  int          pending;

  logic [63:0] key_setting [NUM_KEY_SLOTS];
  logic [7:0]  request_bytes[$];
  bit          in_burst;
  bit          out_burst;

  string hex_chars   = "0123456789abcdefABCDEFgG";
  string key_chars   = "abkeynmz&=+%";
  string value_chars = "xyz =&q";

  form_urlencoded_field_parser_unit dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  fup_scoreboard u_scoreboard (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Pack a key name the way the registers hold it
  function automatic logic [63:0] pack_key(input string s);
    logic [63:0] k;
    k = 64'd0;
    for (int i = 0; i < s.len() && i < 8; i++) k[8*i +: 8] = s[i];
    return k;
  endfunction

  // Offer one word after a random gap, hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, final_byte: fin};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Hold input off until every predicted result is out and the pipe is quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all registers; call only while idle
  task automatic apply_setting(input logic [63:0] k0, input logic [63:0] k1,
                               input logic [63:0] k2, input logic [63:0] k3,
                               input logic [63:0] k4, input logic [63:0] k5,
                               input logic [7:0] lim);
    key_setting = '{k0, k1, k2, k3, k4, k5};
    for (int i = 0; i <= NUM_KEY_SLOTS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == NUM_KEY_SLOTS) ? CFG_VALUE_LIMIT : 3'(i);
      cfg_data  <= (i == NUM_KEY_SLOTS) ? {56'd0, lim} : key_setting[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic add_key_bytes(input int slot);
    logic [63:0] k;
    k = key_setting[slot];
    if (k == 64'd0) begin
      request_bytes.push_back("z");
      request_bytes.push_back("z");
    end else begin
      for (int i = 0; i < 8; i++)
        if (k[8*i +: 8] != 8'd0) request_bytes.push_back(k[8*i +: 8]);
    end
  endtask

  function automatic logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 3) return CH_PERCENT;
    if (r < 5) return CH_PLUS;
    if (r < 11) return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
    if (r < 14) return 8'($urandom_range(0, 255));
    return value_chars[$urandom_range(0, value_chars.len() - 1)];
  endfunction

  // Build a request: key=value segments joined by '&', some with no key or no value
  task automatic build_request();
    int nseg;
    int r;
    request_bytes.delete();
    nseg = $urandom_range(1, 4);
    for (int s = 0; s < nseg; s++) begin
      if (s > 0) request_bytes.push_back(CH_AMP);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        add_key_bytes($urandom_range(0, NUM_KEY_SLOTS - 1));
      end else if (r < 9) begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 4) == 0) request_bytes.push_back(8'($urandom_range(0, 255)));
          else request_bytes.push_back(key_chars[$urandom_range(0, key_chars.len() - 1)]);
        end
      end
      if ($urandom_range(0, 6) != 0) begin
        request_bytes.push_back(CH_EQUAL);
        repeat ($urandom_range(0, 12)) request_bytes.push_back(value_char());
      end
    end
    if (request_bytes.size() == 0) request_bytes.push_back("a");
  endtask

  // Mostly generated key=value requests, some raw noise, one mid-phase pause
  task automatic run_random(input int count);
    int  sent;
    bit  paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      in_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
          sent++;
        end
      end else begin
        build_request();
        foreach (request_bytes[i]) send_byte(request_bytes[i], i == request_bytes.size() - 1);
        sent += request_bytes.size();
      end
      if (!paused && sent >= count / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
  endtask

  // Result side: random stall per word, with stall-free stretches
  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default limit, mixed key lengths including a full eight-byte key
    apply_setting(pack_key("a"), pack_key("bb"), pack_key("key"), pack_key("name"),
                  pack_key("abcdefgh"), 64'd0, VALUE_LIMIT_RESET);
    // Escape with non-hex digit, plus, duplicate key, key without value
    send_text("a=%4G+&a=1&bb");
    // Overlong key, then an escape cut short by the final byte
    send_text("abcdefghi&key=%F");
    drain();
    run_random(45);

    // All-ones key, separator characters as keys, repeated key, limit zero
    apply_setting(64'hFFFF_FFFF_FFFF_FFFF, pack_key("&"), pack_key("="), pack_key("a"),
                  pack_key("a"), pack_key("%41"), 8'd0);
    run_random(45);

    // Single-letter keys, widest limit
    apply_setting(pack_key("a"), pack_key("b"), pack_key("c"), pack_key("d"),
                  pack_key("e"), pack_key("f"), 8'hFF);
    run_random(45);

    // Tight limit so values get cut
    apply_setting(pack_key("bb"), pack_key("x+"), pack_key("k"), pack_key("zz"),
                  64'd0, pack_key("a"), 8'd2);
    run_random(45);

    repeat (8) @(negedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
design/fup_pkg.sv
design/form_urlencoded_field_parser_unit.sv
design/fup_checker.sv
sim/fup_checker.sv
sim/tb_top.sv
